/* rtl/mads_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mads_pkg
// Shared constants, codes and types of the multichannel ADC average scaler.
// ----------------------------------------------------------------------------
package mads_pkg;

    // Sample count per channel; kept a power of two so the average is a shift.
    localparam int SAMPLES_PER_CHANNEL = 16;
    localparam int CHANNELS            = 4;
    localparam int RING_DEPTH          = SAMPLES_PER_CHANNEL * CHANNELS;
    localparam int POS_W               = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CH_W                = 2;

    localparam int SAMPLE_W   = 12;
    localparam int VALUE_W    = 16;
    localparam int AVG_SHIFT  = $clog2(SAMPLES_PER_CHANNEL);
    localparam int SUM_W      = SAMPLE_W + AVG_SHIFT;

    // avg * 3300 / 4096
    localparam int SCALE_MUL   = 3300;
    localparam int SCALE_SHIFT = 12;
    localparam int PROD1_W     = SAMPLE_W + 12;
    localparam int SCALED_W    = 12;

    localparam int SENSOR_BIAS = 1630;
    localparam int SENS_W      = 18;

    // scaled * 5286 / 1000, division by reciprocal 2^32/1000 plus one correction
    localparam int BATT_MUL     = 5286;
    localparam int BATT_DIV     = 1000;
    localparam int PROD2_W      = 25;
    localparam int RECIP_W      = 23;
    localparam int RECIP_SHIFT  = 32;
    localparam int RECIP_MUL    = int'((64'd1 << RECIP_SHIFT) / BATT_DIV);
    localparam int RECIP_PROD_W = PROD2_W + RECIP_W;
    localparam int QUOT_W       = 15;

    localparam int STANDBY_MV = 5000;

    localparam int NUM_OFFSETS = 3;

    // operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // register indexes
    localparam logic [CH_W-1:0] CFG_CALIB = 2'd0;
    localparam logic [CH_W-1:0] CFG_OFS0  = 2'd1;
    localparam logic [CH_W-1:0] CFG_OFS1  = 2'd2;
    localparam logic [CH_W-1:0] CFG_OFS2  = 2'd3;

    typedef struct packed {
        logic                                 calib;
        logic [NUM_OFFSETS-1:0][VALUE_W-1:0]  offset;
    } cfg_t;

    typedef struct packed {
        logic capture;     // latch sample, read ring entry
        logic update;      // write ring, update sum, advance position
        logic tick_start;  // restart channel walk
        logic step1;
        logic step2;
        logic step3;
        logic step4;
        logic load_out;
        logic next_ch;
    } cmd_t;

    typedef struct packed {
        logic last_ch;
    } status_t;

endpackage

/* rtl/mads_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mads_cfg
// Configuration registers: calibration mode and sensor channel offsets.
// ----------------------------------------------------------------------------
module mads_cfg
    import mads_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    input  logic [CH_W-1:0] cfg_index,
    input  logic [15:0]     cfg_data,
    output cfg_t            cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CALIB: cfg_reg.calib     <= cfg_data[0];
                CFG_OFS0:  cfg_reg.offset[0] <= cfg_data;
                CFG_OFS1:  cfg_reg.offset[1] <= cfg_data;
                CFG_OFS2:  cfg_reg.offset[2] <= cfg_data;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/mads_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mads_ctrl
// Sequencer: sample read-modify-write and per-channel tick walk.
// ----------------------------------------------------------------------------
module mads_ctrl
    import mads_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_operation,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_UPD  = 4'd1;
    localparam logic [3:0] ST_MUL1 = 4'd2;
    localparam logic [3:0] ST_MUL2 = 4'd3;
    localparam logic [3:0] ST_MUL3 = 4'd4;
    localparam logic [3:0] ST_MUL4 = 4'd5;
    localparam logic [3:0] ST_FIN  = 4'd6;
    localparam logic [3:0] ST_OUT  = 4'd7;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == OP_TICK) begin
                        cmd.tick_start = 1'b1;
                        state_next     = ST_MUL1;
                    end else begin
                        cmd.capture = 1'b1;
                        state_next  = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MUL1: begin
                cmd.step1  = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.step2  = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.step3  = 1'b1;
                state_next = ST_MUL4;
            end
            ST_MUL4: begin
                cmd.step4  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.load_out = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.last_ch) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next_ch = 1'b1;
                        state_next  = ST_MUL1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/mads_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mads_dp
// Datapath: sample ring, running sums, scaling pipeline and result register.
// ----------------------------------------------------------------------------
module mads_dp
    import mads_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    input  cfg_t                cfg,
    input  logic [SAMPLE_W-1:0] s_sample,
    output status_t             status,
    output logic [CH_W-1:0]     m_channel,
    output logic [VALUE_W-1:0]  m_value_mv,
    output logic                m_is_battery,
    output logic                m_last,
    output logic                m_standby_request
);

    // ring memory, entries not yet written read as zero via valid bits
    logic [SAMPLE_W-1:0]   ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] ring_vld_reg;
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic                  rd_vld_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [CH_W-1:0]       wr_ch_reg;

    logic [SUM_W-1:0]      sum_reg [CHANNELS];
    logic [CH_W-1:0]       sum_idx;
    logic [SUM_W-1:0]      sum_sel;
    logic [SAMPLE_W-1:0]   old_sample;

    logic [CH_W-1:0]       tick_ch_reg;
    logic                  last_ch;

    logic [PROD1_W-1:0]      prod1_reg;
    logic [SCALED_W-1:0]     scaled;
    logic [PROD2_W-1:0]      prod2_reg;
    logic signed [SENS_W-1:0] sens_reg;
    logic signed [SENS_W-1:0] sens_next;
    logic [VALUE_W-1:0]      ofs_sel;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic [QUOT_W-1:0]       qest_reg;
    logic [PROD2_W-1:0]      prod3_reg;
    logic [PROD2_W-1:0]      rem;
    logic [QUOT_W-1:0]       quot;
    logic [VALUE_W-1:0]      batt_mv;

    logic [CH_W-1:0]    out_ch_reg;
    logic [VALUE_W-1:0] out_val_reg;
    logic               out_batt_reg;
    logic               out_stby_reg;

    assign last_ch        = (tick_ch_reg == CH_W'(CHANNELS - 1));
    assign status.last_ch = last_ch;

    // ring access
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_data_reg <= ring_mem[pos_reg];
            sample_reg  <= s_sample;
        end
        if (cmd.update) begin
            ring_mem[pos_reg] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            pos_reg      <= '0;
            wr_ch_reg    <= '0;
        end else begin
            if (cmd.capture) begin
                rd_vld_reg <= ring_vld_reg[pos_reg];
            end
            if (cmd.update) begin
                ring_vld_reg[pos_reg] <= 1'b1;
                if (pos_reg == POS_W'(RING_DEPTH - 1)) begin
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
                if (wr_ch_reg == CH_W'(CHANNELS - 1)) begin
                    wr_ch_reg <= '0;
                end else begin
                    wr_ch_reg <= wr_ch_reg + 1'b1;
                end
            end
        end
    end

    // one read port on the sums: write channel during update, walk channel otherwise
    assign sum_idx    = cmd.update ? wr_ch_reg : tick_ch_reg;
    assign sum_sel    = sum_reg[sum_idx];
    assign old_sample = rd_vld_reg ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (cmd.update) begin
            sum_reg[sum_idx] <= sum_sel - SUM_W'(old_sample) + SUM_W'(sample_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_ch_reg <= '0;
        end else if (cmd.tick_start) begin
            tick_ch_reg <= '0;
        end else if (cmd.next_ch) begin
            tick_ch_reg <= tick_ch_reg + 1'b1;
        end
    end

    // offset of the current sensor channel, zero in calibration mode
    always_comb begin
        case (tick_ch_reg)
            2'd0:    ofs_sel = cfg.offset[0];
            2'd1:    ofs_sel = cfg.offset[1];
            2'd2:    ofs_sel = cfg.offset[2];
            default: ofs_sel = '0;
        endcase
        if (cfg.calib) begin
            ofs_sel = '0;
        end
    end

    assign scaled    = prod1_reg[SCALE_SHIFT +: SCALED_W];
    assign sens_next = $signed({{(SENS_W - SCALED_W){1'b0}}, scaled})
                       - SENS_W'(SENSOR_BIAS)
                       - {{(SENS_W - VALUE_W){ofs_sel[VALUE_W-1]}}, ofs_sel};
    assign recip_prod = RECIP_PROD_W'(prod2_reg) * RECIP_PROD_W'(RECIP_MUL);
    assign rem        = prod2_reg - prod3_reg;
    // reciprocal estimate is low by at most one
    assign quot       = qest_reg + QUOT_W'(rem >= PROD2_W'(BATT_DIV));
    assign batt_mv    = VALUE_W'(quot);

    always_ff @(posedge aclk) begin
        if (cmd.step1) begin
            prod1_reg <= PROD1_W'(sum_sel[AVG_SHIFT +: SAMPLE_W]) * PROD1_W'(SCALE_MUL);
        end
        if (cmd.step2) begin
            prod2_reg <= PROD2_W'(scaled) * PROD2_W'(BATT_MUL);
            sens_reg  <= sens_next;
        end
        if (cmd.step3) begin
            qest_reg <= recip_prod[RECIP_SHIFT +: QUOT_W];
        end
        if (cmd.step4) begin
            prod3_reg <= PROD2_W'(qest_reg) * PROD2_W'(BATT_DIV);
        end
        if (cmd.load_out) begin
            out_ch_reg   <= tick_ch_reg;
            out_batt_reg <= last_ch;
            if (last_ch) begin
                out_val_reg  <= batt_mv;
                out_stby_reg <= (batt_mv != '0) && (batt_mv < VALUE_W'(STANDBY_MV));
            end else begin
                out_val_reg  <= sens_reg[VALUE_W-1:0];
                out_stby_reg <= 1'b0;
            end
        end
    end

    assign m_channel         = out_ch_reg;
    assign m_value_mv        = out_val_reg;
    assign m_is_battery      = out_batt_reg;
    assign m_last            = out_batt_reg;
    assign m_standby_request = out_stby_reg;

endmodule

/* rtl/multichannel_adc_average_scaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_adc_average_scaler
// Averages interleaved ADC samples per channel and reports scaled millivolts.
// ----------------------------------------------------------------------------
//  channel   ports                         moves
//  input     s_valid/s_ready               sample or tick request
//  result    m_valid/m_ready               one result per channel on a tick
//  config    cfg_valid/cfg_ready           register index and data
//
//  A sample reads the ring entry, then writes the ring and updates the sum.
//  A tick takes the request, then walks each channel through the shared
//  multiply chain (x3300, x5286, reciprocal of 1000, correction), the result
//  load and the wait for m_ready.
//  Reset clears sums, ring position and ring valid bits.
//  While a result waits on m_ready it holds and no new request is taken.
// ----------------------------------------------------------------------------
module multichannel_adc_average_scaler
    import mads_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [SAMPLE_W-1:0] s_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CH_W-1:0]     m_channel,
    output logic [VALUE_W-1:0]  m_value_mv,
    output logic                m_is_battery,
    output logic                m_last,
    output logic                m_standby_request,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CH_W-1:0]     cfg_index,
    input  logic [15:0]         cfg_data
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    mads_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mads_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    mads_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cfg               (cfg),
        .s_sample          (s_sample),
        .status            (status),
        .m_channel         (m_channel),
        .m_value_mv        (m_value_mv),
        .m_is_battery      (m_is_battery),
        .m_last            (m_last),
        .m_standby_request (m_standby_request)
    );

endmodule

/* rtl/mads_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mads_checker
// Port-level checks of the averaging scaler, bound to the top level.
// ----------------------------------------------------------------------------
module mads_checker
    import mads_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_operation,
    input logic [SAMPLE_W-1:0] s_sample,
    input logic                m_valid,
    input logic                m_ready,
    input logic [CH_W-1:0]     m_channel,
    input logic [VALUE_W-1:0]  m_value_mv,
    input logic                m_is_battery,
    input logic                m_last,
    input logic                m_standby_request,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [CH_W-1:0]     cfg_index,
    input logic [15:0]         cfg_data
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_mv) && $stable(m_channel))
        else $error("result changed while stalled");

    // battery result closes the run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_battery == m_last))
        else $error("battery flag and last disagree");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_battery |-> !m_standby_request)
        else $error("standby raised on sensor result");

    // mid-run: no new request until the walk ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> !s_ready && !m_valid)
        else $error("tick run interrupted");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> ##5 m_valid && (m_channel == $past(m_channel, 6) + 1'b1))
        else $error("channel sequence broken");

endmodule

bind multichannel_adc_average_scaler mads_checker u_mads_checker (.*);
